/* design/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants of the max priority queue
// Queue depth, derived widths, command and status codes, result record.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

endpackage

/* design/mpq_if.sv */
// ----------------------------------------------------------------------------
// mpq_if: request and response channels of the max priority queue
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface mpq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mpq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [4:0]         occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_value, input status, input occupancy,
                  output ready);
endinterface

/* design/mpq_ram.sv */
// ----------------------------------------------------------------------------
// mpq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/mpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mpq_ctrl: queue sequencer
// Runs one request at a time against the entry RAM: append, max scan with
// gap closing, or peek; then holds the result until the output takes it.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  mpq_req_if.sink       req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mpq_pkg::rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PEEK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [mpq_pkg::CNT_W-1:0]  count, count_next;
  logic [mpq_pkg::CNT_W-1:0]  idx, idx_next;
  logic [mpq_pkg::IDX_W-1:0]  pos, pos_next;
  logic signed [mpq_pkg::DATA_W-1:0] best, best_next;
  mpq_pkg::rsp_t              rsp_next;

  logic                       wr_en;
  logic [mpq_pkg::IDX_W-1:0]  wr_addr;
  logic [mpq_pkg::DATA_W-1:0] wr_data;
  logic                       rd_en;
  logic [mpq_pkg::IDX_W-1:0]  rd_addr;
  logic [mpq_pkg::DATA_W-1:0] rd_data;

  logic                       take;
  logic [mpq_pkg::CNT_W:0]    idx_inc;
  logic [mpq_pkg::CNT_W:0]    idx_inc2;
  logic [mpq_pkg::CNT_W-1:0]  count_dec;

  mpq_ram #(
    .WIDTH (mpq_pkg::DATA_W),
    .DEPTH (mpq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  assign idx_inc   = {1'b0, idx} + (mpq_pkg::CNT_W+1)'(1);
  assign idx_inc2  = {1'b0, idx} + (mpq_pkg::CNT_W+1)'(2);
  assign count_dec = count - mpq_pkg::CNT_W'(1);
  // first entry always seeds the maximum; later ones win only when strictly greater
  assign take      = (idx == '0) || ($signed(rd_data) > best);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pos_next   = pos;
    best_next  = best;
    rsp_next   = rsp;
    wr_en      = 1'b0;
    wr_addr    = count[mpq_pkg::IDX_W-1:0];
    wr_data    = req.value;
    rd_en      = 1'b0;
    rd_addr    = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          rsp_next.result_value = '0;
          rsp_next.status       = mpq_pkg::ST_OK;
          rsp_next.occupancy    = mpq_pkg::OCC_W'(count);
          state_next            = S_DONE;
          unique case (req.command)
            mpq_pkg::CMD_ENQ: begin
              if (count == mpq_pkg::CNT_W'(mpq_pkg::DEPTH)) begin
                rsp_next.status = mpq_pkg::ST_OVERFLOW;
              end else begin
                wr_en              = 1'b1;
                count_next         = count + mpq_pkg::CNT_W'(1);
                rsp_next.occupancy = mpq_pkg::OCC_W'(count + mpq_pkg::CNT_W'(1));
              end
            end
            mpq_pkg::CMD_DEQ: begin
              if (count == '0) begin
                rsp_next.status = mpq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            mpq_pkg::CMD_PEEK: begin
              if (count == '0) begin
                rsp_next.status = mpq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = S_PEEK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds entry idx
        if (take) begin
          best_next = $signed(rd_data);
          pos_next  = idx[mpq_pkg::IDX_W-1:0];
        end
        if (idx_inc == {1'b0, count}) begin
          if (mpq_pkg::CNT_W'(pos_next) + mpq_pkg::CNT_W'(1) == count) begin
            count_next            = count_dec;
            rsp_next.result_value = best_next;
            rsp_next.status       = mpq_pkg::ST_OK;
            rsp_next.occupancy    = mpq_pkg::OCC_W'(count_dec);
            state_next            = S_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = mpq_pkg::IDX_W'(mpq_pkg::CNT_W'(pos_next) + mpq_pkg::CNT_W'(1));
            idx_next   = mpq_pkg::CNT_W'(pos_next);
            state_next = S_SHIFT;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_inc[mpq_pkg::IDX_W-1:0];
          idx_next = idx_inc[mpq_pkg::CNT_W-1:0];
        end
      end

      S_SHIFT: begin
        // rd_data holds entry idx+1; move it down into idx
        wr_en   = 1'b1;
        wr_addr = idx[mpq_pkg::IDX_W-1:0];
        wr_data = rd_data;
        if (idx_inc2 < {1'b0, count}) begin
          rd_en    = 1'b1;
          rd_addr  = idx_inc2[mpq_pkg::IDX_W-1:0];
          idx_next = idx_inc[mpq_pkg::CNT_W-1:0];
        end else begin
          count_next            = count_dec;
          rsp_next.result_value = best;
          rsp_next.status       = mpq_pkg::ST_OK;
          rsp_next.occupancy    = mpq_pkg::OCC_W'(count_dec);
          state_next            = S_DONE;
        end
      end

      S_PEEK: begin
        rsp_next.result_value = $signed(rd_data);
        rsp_next.status       = mpq_pkg::ST_OK;
        rsp_next.occupancy    = mpq_pkg::OCC_W'(count);
        state_next            = S_DONE;
      end

      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx  <= idx_next;
    pos  <= pos_next;
    best <= best_next;
    rsp  <= rsp_next;
  end

  // never more entries than the store holds
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
    else $error("entry count beyond depth");

  // a write and a read never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write to the same entry");

  // gap closing only moves entries that lie below the count
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx_inc < {1'b0, count}))
    else $error("shift beyond stored entries");

  // overflow reports come only from a full store
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == mpq_pkg::ST_OVERFLOW))
      |-> (count == mpq_pkg::CNT_W'(mpq_pkg::DEPTH)))
    else $error("overflow without full store");

endmodule

/* design/max_priority_queue_scan.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_scan: unsorted-array max priority queue
// Signed 32-bit entries kept in arrival order in a single RAM; enqueue,
// dequeue of the maximum (oldest wins ties) and peek of the oldest entry.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                   transfer
//  -------  ---  ---------------------------------------  -------------------
//  req      in   command[1:0], value[31:0]                valid && ready
//  rsp      out  result_value[31:0], status[1:0],         valid && ready
//                occupancy[4:0]
//
// Dequeue of N stored entries with the maximum at position p makes one RAM
// read per entry for the scan, then one read and one write for each of the
// N - 1 - p entries above p to close the gap, every read through the single
// read port of the entry RAM. Reset clears the sequencer state, the entry
// count and the output flag; the RAM needs no clearing pass. The sequencer
// takes one request at a time; a finished result waits in the output
// register, so the next request is taken while the sink stalls.
// ----------------------------------------------------------------------------
module max_priority_queue_scan (
  input  logic      clk,
  input  logic      rst,
  mpq_req_if.sink   req,
  mpq_rsp_if.source rsp
);

  mpq_pkg::rsp_t ctrl_rsp;
  mpq_pkg::rsp_t out_data;
  logic          ctrl_valid;
  logic          ctrl_ready;
  logic          out_full;

  // Sequencer with the entry RAM behind it
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (ctrl_valid),
    .rsp_ready (ctrl_ready),
    .rsp       (ctrl_rsp)
  );

  // Output register: take a new result when empty or being drained
  assign ctrl_ready = !out_full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (ctrl_valid && ctrl_ready) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  // Hold the payload while stalled; load it only on a handoff
  always_ff @(posedge clk) begin
    if (ctrl_valid && ctrl_ready) begin
      out_data <= ctrl_rsp;
    end
  end

  assign rsp.valid        = out_full;
  assign rsp.result_value = out_data.result_value;
  assign rsp.status       = out_data.status;
  assign rsp.occupancy    = out_data.occupancy;

endmodule

/* tb/max_priority_queue_scan_tb.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_scan_tb: self-checking bench for the max priority queue
// Drives enqueue, dequeue, peek and unused command requests over the valid/ready
// request channel, predicts every response with a queue-based model of the
// store and compares each response field by field, in order, under several
// sender and receiver throttling mixes.
// ----------------------------------------------------------------------------
module max_priority_queue_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The one code of the command field that the block does not define.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int ITEMS_PER_PASS = 188;
  localparam int DRAIN_CYCLES   = 40;   // margin that covers the longest dequeue
  localparam int WATCHDOG_LIMIT = 5000;

  // --------------------------------------------------------------------------
  // Response predictor and checker
  // --------------------------------------------------------------------------
  class mpq_scoreboard;
    logic signed [mpq_pkg::DATA_W-1:0] held_entries[$];  // stored values, oldest first
    mpq_pkg::rsp_t                     expected_rsp[$];
    int                                errors;
    int                                checked;
    int                                cmd_seen[4];
    int                                overflow_seen;
    int                                empty_seen;

    function void note_request(logic [1:0] cmd, logic signed [mpq_pkg::DATA_W-1:0] val);
      mpq_pkg::rsp_t                     rsp;
      logic signed [mpq_pkg::DATA_W-1:0] best;
      int                                pos;
      rsp.result_value = '0;
      rsp.status       = mpq_pkg::ST_OK;
      cmd_seen[cmd]++;
      case (cmd)
        mpq_pkg::CMD_ENQ: begin
          if (held_entries.size() >= mpq_pkg::DEPTH) begin
            rsp.status = mpq_pkg::ST_OVERFLOW;
          end else begin
            held_entries.push_back(val);
          end
        end
        mpq_pkg::CMD_DEQ: begin
          if (held_entries.size() == 0) begin
            rsp.status = mpq_pkg::ST_EMPTY;
          end else begin
            // strict compare keeps the oldest of equal maxima
            best = held_entries[0];
            pos  = 0;
            for (int i = 1; i < held_entries.size(); i++) begin
              if (held_entries[i] > best) begin
                best = held_entries[i];
                pos  = i;
              end
            end
            held_entries.delete(pos);
            rsp.result_value = best;
          end
        end
        mpq_pkg::CMD_PEEK: begin
          if (held_entries.size() == 0) begin
            rsp.status = mpq_pkg::ST_EMPTY;
          end else begin
            rsp.result_value = held_entries[0];
          end
        end
        default: begin
        end
      endcase
      if (rsp.status == mpq_pkg::ST_OVERFLOW) overflow_seen++;
      if (rsp.status == mpq_pkg::ST_EMPTY) empty_seen++;
      rsp.occupancy = mpq_pkg::OCC_W'(held_entries.size());
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(mpq_pkg::rsp_t got);
      mpq_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with nothing outstanding: result_value %0d status %0d occupancy %0d",
               got.result_value, got.status, got.occupancy);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, actual %0d", want.result_value, got.result_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  int   idle_pct;    // chance in a hundred that the sender pauses after a request
  int   stall_pct;   // chance in a hundred that the receiver holds ready low

  mpq_req_if req_ch ();
  mpq_rsp_if rsp_ch ();

  max_priority_queue_scan dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mpq_scoreboard book;
  mpq_pkg::rsp_t seen_rsp;

  assign seen_rsp = {rsp_ch.result_value, rsp_ch.status, rsp_ch.occupancy};

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Receiver: decide ready for the next edge on every falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sample accepted responses at the rising edge and check them in order.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      book.check_response(seen_rsp);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst === 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("no request or response accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Present one request at the falling edge and hold it until accepted.
  // Valid stays high on return, so a back-to-back request is a single update.
  task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] val);
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.value   <= val;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    book.note_request(cmd, val);
  endtask

  // Drop valid for a number of cycles; scramble the payload meanwhile.
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    req_ch.valid   <= 1'b0;
    req_ch.command <= 2'($urandom);
    req_ch.value   <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Insert a gap after a request at the rate of the current mix: mostly short
  // gaps, sometimes long enough to cover a whole dequeue.
  task automatic maybe_pause();
    if ($urandom_range(99) < idle_pct) begin
      if ($urandom_range(3) == 0) begin
        pause_sender($urandom_range(8, 40));
      end else begin
        pause_sender($urandom_range(1, 4));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic signed [31:0] fill_pattern[4];
    logic [1:0]         cmd;
    logic signed [31:0] val;
    int                 mode;         // 0 fill, 1 drain, 2 mixed
    int                 burst_left;
    int                 roll;

    book           = new();
    idle_pct       = 0;
    stall_pct      = 0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.command = mpq_pkg::CMD_ENQ;
    req_ch.value   = '0;

    // Hold reset for the fixed count, then release at a falling edge.
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty reports and the unused command on an empty store.
    send_request(mpq_pkg::CMD_PEEK, 32'sh1234_5678);
    send_request(mpq_pkg::CMD_DEQ, VAL_MAX);
    send_request(CMD_UNUSED, -32'sd1);

    // Equal maxima: [7, MIN, 7] must lose the first 7, so the peek sees MIN.
    send_request(mpq_pkg::CMD_ENQ, 32'sd7);
    send_request(mpq_pkg::CMD_ENQ, VAL_MIN);
    send_request(mpq_pkg::CMD_ENQ, 32'sd7);
    send_request(mpq_pkg::CMD_DEQ, 32'sd0);
    send_request(mpq_pkg::CMD_PEEK, 32'sd0);

    // Extremes of the value field, then fill to full and overflow.
    send_request(mpq_pkg::CMD_ENQ, VAL_MAX);
    send_request(mpq_pkg::CMD_ENQ, -32'sd1);
    fill_pattern = '{32'sh0, 32'sh5555_5555, 32'shAAAA_AAAA, VAL_MIN};
    for (int i = 0; i < 12; i++) begin
      send_request(mpq_pkg::CMD_ENQ, fill_pattern[i % 4]);
    end
    send_request(mpq_pkg::CMD_ENQ, 32'sd99);
    send_request(mpq_pkg::CMD_DEQ, 32'sd0);
    send_request(CMD_UNUSED, 32'sd0);

    // Random: four throttling mixes, each with fill, drain and mixed bursts.
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      burst_left = 0;
      mode       = 0;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        if (burst_left == 0) begin
          mode       = $urandom_range(2);
          burst_left = $urandom_range(8, 40);
        end
        burst_left--;

        // Weight the command by burst mode so full and empty both get hit.
        roll = $urandom_range(99);
        case (mode)
          0: cmd = (roll < 80) ? mpq_pkg::CMD_ENQ : (roll < 90) ? mpq_pkg::CMD_DEQ :
                   (roll < 98) ? mpq_pkg::CMD_PEEK : CMD_UNUSED;
          1: cmd = (roll < 75) ? mpq_pkg::CMD_DEQ : (roll < 85) ? mpq_pkg::CMD_PEEK :
                   (roll < 98) ? mpq_pkg::CMD_ENQ : CMD_UNUSED;
          default: cmd = (roll < 45) ? mpq_pkg::CMD_ENQ : (roll < 85) ? mpq_pkg::CMD_DEQ :
                         (roll < 97) ? mpq_pkg::CMD_PEEK : CMD_UNUSED;
        endcase

        // Narrow values make ties common; extremes and full words cover the rest.
        roll = $urandom_range(99);
        if (roll < 40) begin
          val = $signed($urandom_range(8)) - 32'sd4;
        end else if (roll < 50) begin
          case ($urandom_range(3))
            0: val = VAL_MAX;
            1: val = VAL_MIN;
            2: val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end else begin
          val = $urandom;
        end

        send_request(cmd, val);
        maybe_pause();
      end
    end

    // Drop valid, then wait for every outstanding response plus a margin.
    pause_sender(1);
    stall_pct = 0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.pending() != 0) begin
      $error("%0d expected responses never arrived", book.pending());
      book.errors += book.pending();
    end

    $display("covered %0d enqueue, %0d dequeue, %0d peek and %0d unused-command requests",
             book.cmd_seen[mpq_pkg::CMD_ENQ], book.cmd_seen[mpq_pkg::CMD_DEQ],
             book.cmd_seen[mpq_pkg::CMD_PEEK], book.cmd_seen[CMD_UNUSED]);
    $display("checked %0d responses, %0d overflow and %0d empty reports, %0d mismatches",
             book.checked, book.overflow_seen, book.empty_seen, book.errors);
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/mpq_pkg.sv
design/mpq_if.sv
design/mpq_ram.sv
design/mpq_ctrl.sv
design/max_priority_queue_scan.sv
tb/max_priority_queue_scan_tb.sv
